@@ rtl/core/bank_switch_mapper_scanline_irq_macros.svh @@
// Assertion macros shared by the bank mapper RTL.
`ifndef BANK_SWITCH_MAPPER_SCANLINE_IRQ_MACROS_SVH
`define BANK_SWITCH_MAPPER_SCANLINE_IRQ_MACROS_SVH

// Same-cycle implication, held off during reset.
`define BSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define BSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bsm_pkg.sv @@
// Package with widths, codes, control types and helpers of the bank mapper.
`default_nettype none

package bsm_pkg;

    localparam int CMD_W      = 2;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int MAP_W      = 19;
    localparam int COUNT_W    = 7;
    localparam int PRG_BANK_W = 6;
    localparam int CHR_BANK_W = 8;
    localparam int PRG_SLOTS  = 4;
    localparam int CHR_SLOTS  = 8;
    localparam int PRG_SHIFT  = 13;
    localparam int CHR_SHIFT  = 10;

    localparam logic [COUNT_W-1:0] COUNT_MIN   = 7'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 7'd64;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd32;

    // Bus commands
    typedef enum logic [CMD_W-1:0] {
        CMD_CPU_WRITE  = 2'd0,
        CMD_CPU_READ   = 2'd1,
        CMD_PPU_ACCESS = 2'd2,
        CMD_UNUSED     = 2'd3
    } t_cmd;

    // 8KB register windows above 8000
    typedef enum logic [1:0] {
        WIN_BANK      = 2'd0,
        WIN_MIRROR    = 2'd1,
        WIN_IRQ_LATCH = 2'd2,
        WIN_IRQ_CTRL  = 2'd3
    } t_win;

    // Bank register numbers
    localparam logic [2:0] REG_CHR_2K_LAST = 3'd1;
    localparam logic [2:0] REG_CHR_1K_BASE = 3'd2;
    localparam logic [2:0] REG_PRG_SWITCH  = 3'd6;

    // Control from the sequencer to the scanline counter
    typedef struct packed {
        logic              ppu_access;
        logic              a12;
        logic              latch_wr;
        logic              reload_wr;
        logic              enable_wr;
        logic              disable_wr;
        logic [DATA_W-1:0] wdata;
    } t_irq_ctl;

    // Clamp the bank count to the supported range
    function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] c);
        logic [COUNT_W-1:0] r;
        if (c < COUNT_MIN) begin
            r = COUNT_MIN;
        end else if (c > COUNT_MAX) begin
            r = COUNT_MAX;
        end else begin
            r = c;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/bsm_in_if.sv @@
// Request channel carrying one bus access per transaction.
`default_nettype none

interface bsm_in_if
    import bsm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;

    modport source (output valid, output command, output address, output data,
                    input ready);
    modport sink   (input valid, input command, input address, input data,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/bsm_out_if.sv @@
// Result channel carrying the mapped address and status per transaction.
`default_nettype none

interface bsm_out_if
    import bsm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [MAP_W-1:0] mapped_address;
    logic             irq_line;
    logic             mirror_horizontal;

    modport source (output valid, output mapped_address, output irq_line,
                    output mirror_horizontal, input ready);
    modport sink   (input valid, input mapped_address, input irq_line,
                    input mirror_horizontal, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bsm_cfg_if.sv @@
// Configuration write channel for the PRG bank count.
`default_nettype none

interface bsm_cfg_if
    import bsm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] prg_bank_count;

    modport source (output valid, output prg_bank_count, input ready);
    modport sink   (input valid, input prg_bank_count, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bsm_mod_unit.sv @@
// Iterative restoring remainder unit: one quotient bit per cycle.
`default_nettype none
`include "bank_switch_mapper_scanline_irq_macros.svh"

module bsm_mod_unit
    import bsm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [PRG_BANK_W-1:0] i_dividend,
    input  wire logic [COUNT_W-1:0]    i_divisor,
    output logic                       o_done,
    output logic [PRG_BANK_W-1:0]      o_remainder
);

    localparam int CNT_W = $clog2(PRG_BANK_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PRG_BANK_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [PRG_BANK_W-1:0] r_dvd;
    logic [COUNT_W-1:0]    r_dsr;
    logic [COUNT_W-1:0]    r_rem;
    logic [COUNT_W-1:0]    w_shifted;
    logic [COUNT_W-1:0]    n_rem;

    // Shift in the next dividend bit and subtract when it fits
    always_comb begin
        w_shifted = {r_rem[COUNT_W-2:0], r_dvd[PRG_BANK_W-1]};
        if (w_shifted >= r_dsr) begin
            n_rem = w_shifted - r_dsr;
        end else begin
            n_rem = w_shifted;
        end
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operands and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[PRG_BANK_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem[PRG_BANK_W-1:0];

    `BSM_ASSERT_IMP(a_rem_below_divisor, i_clk, i_rst_n, r_done, r_rem < r_dsr, "remainder not below divisor")

endmodule

`default_nettype wire

@@ rtl/core/bsm_irq_ctr.sv @@
// Scanline counter with A12 edge detect and the old reload behavior.
`default_nettype none
`include "bank_switch_mapper_scanline_irq_macros.svh"

module bsm_irq_ctr
    import bsm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_irq_ctl i_ctl,
    output logic          o_irq_pending
);

    logic              r_a12_prev;
    logic [DATA_W-1:0] r_count;
    logic [DATA_W-1:0] r_latch;
    logic              r_reload;
    logic              r_enabled;
    logic              r_pending;
    logic              w_clock;

    // Clock the counter on a rising A12 seen by a PPU access
    assign w_clock = i_ctl.ppu_access && i_ctl.a12 && !r_a12_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a12_prev <= 1'b0;
            r_count    <= '0;
            r_latch    <= '0;
            r_reload   <= 1'b0;
            r_enabled  <= 1'b0;
            r_pending  <= 1'b0;
        end else begin
            if (i_ctl.ppu_access) begin
                r_a12_prev <= i_ctl.a12;
            end
            if (i_ctl.latch_wr) begin
                r_latch <= i_ctl.wdata;
            end
            if (i_ctl.reload_wr) begin
                r_reload <= 1'b1;
            end
            if (i_ctl.enable_wr) begin
                r_enabled <= 1'b1;
            end
            if (i_ctl.disable_wr) begin
                r_enabled <= 1'b0;
                r_pending <= 1'b0;
            end
            if (w_clock) begin
                if (r_reload) begin
                    r_reload <= 1'b0;
                    r_count  <= r_latch;
                    if (r_latch == '0 && r_enabled) begin
                        r_pending <= 1'b1;
                    end
                end else begin
                    if (r_count == DATA_W'(1) && r_enabled) begin
                        r_pending <= 1'b1;
                    end
                    if (r_count == '0) begin
                        r_count <= r_latch;
                    end else begin
                        r_count <= r_count - 1'b1;
                    end
                end
            end
        end
    end

    assign o_irq_pending = r_pending;

    `BSM_ASSERT_IMP(a_irq_needs_enable, i_clk, i_rst_n, $rose(r_pending), $past(r_enabled), "irq raised while disabled")
    `BSM_ASSERT_NXT(a_disable_clears, i_clk, i_rst_n, i_ctl.disable_wr, !r_pending && !r_enabled, "disable did not clear irq")

endmodule

`default_nettype wire

@@ rtl/core/bank_switch_mapper_scanline_irq.sv @@
// Top level of the bank mapper: sequencer, bank registers and result stage.
// A CPU read, a PPU access or any register write other than a PRG bank data
// write is accepted in the idle state, executed in the execute state and
// then offered as a result in the result state. A bank data write to R6 or
// R7 reduces the bank number modulo the PRG bank count in the shared
// remainder unit, one bit per cycle, in a wait state between the execute and
// the result state. The block takes one item at a time and is ready again
// the cycle after its result is taken. Every result carries the IRQ line and
// the mirroring as they stand after that item.
`default_nettype none
`include "bank_switch_mapper_scanline_irq_macros.svh"

module bank_switch_mapper_scanline_irq
    import bsm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bsm_in_if.sink    i_req,
    bsm_cfg_if.sink   i_cfg,
    bsm_out_if.source o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MOD_WAIT,
        S_RESULT
    } t_state;

    t_state                r_state;
    t_cmd                  r_cmd;
    logic [ADDR_W-1:0]     r_addr;
    logic [DATA_W-1:0]     r_data;
    logic [COUNT_W-1:0]    r_count;
    logic [DATA_W-1:0]     r_bank_sel;
    logic [PRG_BANK_W-1:0] r_prg [PRG_SLOTS];
    logic [CHR_BANK_W-1:0] r_chr [CHR_SLOTS];
    logic                  r_mirror;
    logic [MAP_W-1:0]      r_mapped;

    logic [COUNT_W-1:0]    w_eff;
    logic [COUNT_W-1:0]    w_cfg_eff;
    t_win                  w_win;
    logic                  w_odd;
    logic                  w_reg_write;
    logic                  w_prg_data_wr;
    logic [2:0]            w_reg;
    logic [2:0]            w_reg_minus2;
    logic [DATA_W-1:0]     w_sel_diff;
    logic                  w_mod_done;
    logic [PRG_BANK_W-1:0] w_mod_rem;
    logic                  w_irq_pending;
    t_irq_ctl              w_irq_ctl;

    // Decode the held transaction
    assign w_eff         = eff_count(r_count);
    assign w_cfg_eff     = eff_count(i_cfg.prg_bank_count);
    assign w_win         = t_win'(r_addr[14:13]);
    assign w_odd         = r_addr[0];
    assign w_reg_write   = (r_cmd == CMD_CPU_WRITE) && r_addr[15];
    assign w_reg         = r_bank_sel[2:0];
    assign w_reg_minus2  = w_reg - REG_CHR_1K_BASE;
    assign w_sel_diff    = r_data ^ r_bank_sel;
    assign w_prg_data_wr = w_reg_write && (w_win == WIN_BANK) && w_odd
                           && (w_reg >= REG_PRG_SWITCH);

    // Counter controls, issued during the execute cycle only
    always_comb begin
        w_irq_ctl       = '0;
        w_irq_ctl.wdata = r_data;
        w_irq_ctl.a12   = r_addr[12];
        if (r_state == S_EXEC) begin
            w_irq_ctl.ppu_access = (r_cmd == CMD_PPU_ACCESS);
            if (w_reg_write && (w_win == WIN_IRQ_LATCH)) begin
                w_irq_ctl.latch_wr  = !w_odd;
                w_irq_ctl.reload_wr = w_odd;
            end
            if (w_reg_write && (w_win == WIN_IRQ_CTRL)) begin
                w_irq_ctl.enable_wr  = w_odd;
                w_irq_ctl.disable_wr = !w_odd;
            end
        end
    end

    bsm_mod_unit u_mod (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     ((r_state == S_EXEC) && w_prg_data_wr),
        .i_dividend  (r_data[PRG_BANK_W-1:0]),
        .i_divisor   (w_eff),
        .o_done      (w_mod_done),
        .o_remainder (w_mod_rem)
    );

    bsm_irq_ctr u_irq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_irq_ctl),
        .o_irq_pending (w_irq_pending)
    );

    // Capture the transaction
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_cmd  <= t_cmd'(i_req.command);
            r_addr <= i_req.address;
            r_data <= i_req.data;
        end
    end

    // Sequencer, bank registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= COUNT_RESET;
            r_bank_sel <= '0;
            r_prg[0]   <= '0;
            r_prg[1]   <= '0;
            r_prg[2]   <= PRG_BANK_W'(COUNT_RESET - 7'd2);
            r_prg[3]   <= PRG_BANK_W'(COUNT_RESET - 7'd1);
            for (int i = 0; i < CHR_SLOTS; i++) begin
                r_chr[i] <= '0;
            end
            r_mirror   <= 1'b0;
            r_mapped   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    // Reload the fixed slots on a bank count write
                    if (i_cfg.valid && i_cfg.ready) begin
                        r_count <= i_cfg.prg_bank_count;
                        if (r_bank_sel[6]) begin
                            r_prg[0] <= PRG_BANK_W'(w_cfg_eff - 7'd2);
                        end else begin
                            r_prg[2] <= PRG_BANK_W'(w_cfg_eff - 7'd2);
                        end
                        r_prg[3] <= PRG_BANK_W'(w_cfg_eff - 7'd1);
                    end
                    if (i_req.valid && i_req.ready) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_mapped <= '0;
                    r_state  <= w_prg_data_wr ? S_MOD_WAIT : S_RESULT;
                    case (r_cmd)
                        CMD_CPU_WRITE: begin
                            if (w_reg_write && (w_win == WIN_BANK) && !w_odd) begin
                                // Bank select: swap slots on a mode change
                                if (w_sel_diff[6]) begin
                                    r_prg[0] <= r_prg[2];
                                    r_prg[2] <= r_prg[0];
                                end
                                if (w_sel_diff[7]) begin
                                    for (int i = 0; i < CHR_SLOTS / 2; i++) begin
                                        r_chr[i]                 <= r_chr[i + CHR_SLOTS / 2];
                                        r_chr[i + CHR_SLOTS / 2] <= r_chr[i];
                                    end
                                end
                                r_bank_sel <= r_data;
                            end
                            if (w_reg_write && (w_win == WIN_BANK) && w_odd) begin
                                // Bank data for CHR registers
                                if (w_reg <= REG_CHR_2K_LAST) begin
                                    r_chr[{r_bank_sel[7], w_reg[0], 1'b0}] <=
                                        {r_data[DATA_W-1:1], 1'b0};
                                    r_chr[{r_bank_sel[7], w_reg[0], 1'b1}] <=
                                        {r_data[DATA_W-1:1], 1'b1};
                                end else if (w_reg < REG_PRG_SWITCH) begin
                                    r_chr[{~r_bank_sel[7], w_reg_minus2[1:0]}] <= r_data;
                                end
                            end
                            if (w_reg_write && (w_win == WIN_MIRROR) && !w_odd) begin
                                r_mirror <= r_data[0];
                            end
                        end
                        CMD_CPU_READ: begin
                            r_mapped <= {r_prg[r_addr[14:13]], r_addr[PRG_SHIFT-1:0]};
                        end
                        CMD_PPU_ACCESS: begin
                            r_mapped <= MAP_W'({r_chr[r_addr[12:10]],
                                                r_addr[CHR_SHIFT-1:0]});
                        end
                        default: begin
                            r_mapped <= '0;
                        end
                    endcase
                end
                S_MOD_WAIT: begin
                    // Store the reduced PRG bank number
                    if (w_mod_done) begin
                        if (w_reg == REG_PRG_SWITCH) begin
                            r_prg[{r_bank_sel[6], 1'b0}] <= w_mod_rem;
                        end else begin
                            r_prg[1] <= w_mod_rem;
                        end
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Handshakes and result
    assign i_req.ready             = (r_state == S_IDLE);
    assign i_cfg.ready             = (r_state == S_IDLE);
    assign o_rsp.valid             = (r_state == S_RESULT);
    assign o_rsp.mapped_address    = r_mapped;
    assign o_rsp.irq_line          = w_irq_pending;
    assign o_rsp.mirror_horizontal = r_mirror;

    `BSM_ASSERT_IMP(a_last_slot_fixed, i_clk, i_rst_n, 1'b1, r_prg[3] == PRG_BANK_W'(w_eff - 7'd1), "last PRG slot lost its fixed bank")
    `BSM_ASSERT_NXT(a_mod_to_result, i_clk, i_rst_n, (r_state == S_MOD_WAIT) && w_mod_done, o_rsp.valid, "result missing after remainder")

endmodule

`default_nettype wire

@@ verif/bsm_checker.sv @@
// Checker for the bank mapper: predicts each mapped access and compares results.
module bsm_checker
    import bsm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bsm_in_if         i_req,
    bsm_cfg_if        i_cfg,
    bsm_out_if        i_rsp,
    output int        o_fail_count,
    output int        o_outstanding
);

    localparam logic [2:0] REG_CHR_1K_LAST = 3'd5;
    localparam int         MAX_PRINTS      = 200;

    typedef struct packed {
        logic [MAP_W-1:0] mapped;
        logic             irq;
        logic             mirror;
    } t_mapping;

    // Predicted mapper state
    logic [COUNT_W-1:0]    bank_count;
    logic [7:0]            select_q;
    logic [PRG_BANK_W-1:0] prg_bank [PRG_SLOTS];
    logic [CHR_BANK_W-1:0] chr_bank [CHR_SLOTS];
    logic                  a12_last;
    logic [7:0]            scan_count;
    logic [7:0]            scan_latch;
    logic                  reload_armed;
    logic                  irq_on;
    logic                  irq_flag;
    logic                  mirror_h;

    t_mapping pending_maps[$];
    int       fails = 0;
    int       result_index = 0;

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fails < MAX_PRINTS) begin
            $display("mismatch at result %0d: %0s got 0x%0h expected 0x%0h (t=%0t)",
                     result_index, what, got, want, $time);
        end
        fails++;
    endtask

    // Clamp the bank count to the range the mapper supports
    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] c);
        logic [COUNT_W-1:0] r;
        if (c < COUNT_MIN) begin
            r = COUNT_MIN;
        end else if (c > COUNT_MAX) begin
            r = COUNT_MAX;
        end else begin
            r = c;
        end
        return r;
    endfunction

    // Reload the last slot and the fixed second-last slot of the current PRG mode
    task automatic reload_fixed();
        logic [COUNT_W-1:0] c;
        c = clamp_count(bank_count);
        if (select_q[6]) begin
            prg_bank[0] = PRG_BANK_W'(c - 7'd2);
        end else begin
            prg_bank[2] = PRG_BANK_W'(c - 7'd2);
        end
        prg_bank[3] = PRG_BANK_W'(c - 7'd1);
    endtask

    task automatic init_state();
        bank_count   = COUNT_RESET;
        select_q     = '0;
        for (int i = 0; i < PRG_SLOTS; i++) prg_bank[i] = '0;
        for (int i = 0; i < CHR_SLOTS; i++) chr_bank[i] = '0;
        a12_last     = 1'b0;
        scan_count   = '0;
        scan_latch   = '0;
        reload_armed = 1'b0;
        irq_on       = 1'b0;
        irq_flag     = 1'b0;
        mirror_h     = 1'b0;
        reload_fixed();
    endtask

    // Swap PRG slots 0/2 and the CHR halves on mode changes
    task automatic write_select(input logic [7:0] v);
        logic [7:0]            diff;
        logic [PRG_BANK_W-1:0] keep_prg;
        logic [CHR_BANK_W-1:0] keep_chr;
        diff = v ^ select_q;
        if (diff[6]) begin
            keep_prg    = prg_bank[0];
            prg_bank[0] = prg_bank[2];
            prg_bank[2] = keep_prg;
        end
        if (diff[7]) begin
            for (int i = 0; i < 4; i++) begin
                keep_chr        = chr_bank[i];
                chr_bank[i]     = chr_bank[i + 4];
                chr_bank[i + 4] = keep_chr;
            end
        end
        select_q = v;
    endtask

    // Load the bank register picked by the select register
    task automatic write_bank(input logic [7:0] v);
        logic [2:0]            r;
        logic [2:0]            slot;
        logic [CHR_BANK_W-1:0] b;
        logic [COUNT_W-1:0]    c;
        r = select_q[2:0];
        if (r <= REG_CHR_2K_LAST) begin
            b    = v & 8'hFE;
            slot = {select_q[7], r[0], 1'b0};
            chr_bank[slot]        = b;
            chr_bank[slot | 3'd1] = b + 8'd1;
        end else if (r <= REG_CHR_1K_LAST) begin
            slot = {~select_q[7], 2'(r - REG_CHR_1K_BASE)};
            chr_bank[slot] = v;
        end else begin
            c = clamp_count(bank_count);
            if (r == REG_PRG_SWITCH) begin
                prg_bank[{select_q[6], 1'b0}] = PRG_BANK_W'(int'(v[5:0]) % int'(c));
            end else begin
                prg_bank[1] = PRG_BANK_W'(int'(v[5:0]) % int'(c));
            end
        end
    endtask

    // Decode a CPU write; anything below 8000 is dropped
    task automatic cpu_write(input logic [ADDR_W-1:0] addr, input logic [7:0] v);
        if (addr[15]) begin
            case (t_win'(addr[14:13]))
                WIN_BANK: begin
                    if (addr[0]) write_bank(v);
                    else write_select(v);
                end
                WIN_MIRROR: begin
                    if (!addr[0]) mirror_h = v[0];
                end
                WIN_IRQ_LATCH: begin
                    if (addr[0]) reload_armed = 1'b1;
                    else scan_latch = v;
                end
                default: begin
                    if (addr[0]) begin
                        irq_on = 1'b1;
                    end else begin
                        irq_on   = 1'b0;
                        irq_flag = 1'b0;
                    end
                end
            endcase
        end
    endtask

    // Advance the scanline counter on a rising A12
    task automatic clock_scanline();
        if (reload_armed) begin
            reload_armed = 1'b0;
            scan_count   = scan_latch;
            if (scan_count == 8'd0 && irq_on) irq_flag = 1'b1;
        end else begin
            if (scan_count == 8'd1 && irq_on) irq_flag = 1'b1;
            if (scan_count == 8'd0) scan_count = scan_latch;
            else scan_count = scan_count - 8'd1;
        end
    endtask

    // Work out the result of one bus access and update the state
    task automatic predict_mapping(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                                   input logic [DATA_W-1:0] data, output t_mapping m);
        m.mapped = '0;
        case (t_cmd'(cmd))
            CMD_CPU_WRITE: begin
                cpu_write(addr, data);
            end
            CMD_CPU_READ: begin
                m.mapped = {prg_bank[addr[14:13]], addr[12:0]};
            end
            CMD_PPU_ACCESS: begin
                m.mapped = {1'b0, chr_bank[addr[12:10]], addr[9:0]};
                if (addr[12]) begin
                    if (!a12_last) clock_scanline();
                    a12_last = 1'b1;
                end else begin
                    a12_last = 1'b0;
                end
            end
            default: begin
            end
        endcase
        m.irq    = irq_flag;
        m.mirror = mirror_h;
    endtask

    // Track every transaction on the three channels
    always @(posedge i_clk) begin : watch
        t_mapping want;
        if (!i_rst_n) begin
            init_state();
            pending_maps.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                bank_count = i_cfg.prg_bank_count;
                reload_fixed();
            end
            if (i_req.valid && i_req.ready) begin
                predict_mapping(i_req.command, i_req.address, i_req.data, want);
                pending_maps.insert(pending_maps.size(), want);
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_maps.size() == 0) begin
                    report_mismatch("result with nothing expected",
                                    32'(i_rsp.mapped_address), 32'd0);
                end else begin
                    want = pending_maps.pop_front();
                    if (i_rsp.mapped_address !== want.mapped)
                        report_mismatch("mapped_address", 32'(i_rsp.mapped_address),
                                        32'(want.mapped));
                    if (i_rsp.irq_line !== want.irq)
                        report_mismatch("irq_line", 32'(i_rsp.irq_line), 32'(want.irq));
                    if (i_rsp.mirror_horizontal !== want.mirror)
                        report_mismatch("mirror_horizontal", 32'(i_rsp.mirror_horizontal),
                                        32'(want.mirror));
                end
                result_index++;
            end
        end
        o_outstanding <= pending_maps.size();
        o_fail_count  <= fails;
    end

endmodule

@@ verif/tb.sv @@
// Testbench top of the bank mapper: clock, reset, stimulus and verdict.
module tb;
    import bsm_pkg::*;

    localparam int   CYCLE_LIMIT  = 400000;
    localparam int   LONG_HOLD    = 160;
    localparam int   PHASE_ITEMS  = 230;
    localparam int   SETTLE       = 12;
    localparam logic REG_EVEN     = 1'b0;
    localparam logic REG_ODD      = 1'b1;

    logic i_clk;
    logic i_rst_n;
    logic gaps_on;
    int   hold_asked;
    int   fail_count;
    int   outstanding;
    int   cycle_count;
    int   items_sent;

    bsm_in_if  req_bus ();
    bsm_cfg_if cfg_bus ();
    bsm_out_if rsp_bus ();

    bank_switch_mapper_scanline_irq u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .i_cfg   (cfg_bus),
        .o_rsp   (rsp_bus)
    );

    bsm_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_bus),
        .i_cfg         (cfg_bus),
        .i_rsp         (rsp_bus),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random stall per result, long hold-off on request
    initial begin : sink_side
        int stall;
        int hold_seen;
        hold_seen     = 0;
        rsp_bus.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_asked != hold_seen) begin
                hold_seen = hold_asked;
                stall     = LONG_HOLD;
            end else begin
                stall = gaps_on ? $urandom_range(0, 7) : 0;
            end
            if (stall > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_bus.valid);
        end
    end

    // Register address in one of the four windows, optionally with random mirror bits
    function automatic logic [ADDR_W-1:0] reg_addr(input t_win win, input logic odd,
                                                   input logic spread);
        logic [11:0] mid;
        mid = spread ? 12'($urandom) : 12'd0;
        return {1'b1, win, mid, odd};
    endfunction

    // Offer one bus access after a random gap and hold it until accepted
    task automatic send_access(input t_cmd cmd, input logic [ADDR_W-1:0] addr,
                               input logic [DATA_W-1:0] data);
        int gap;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid   <= 1'b1;
        req_bus.command <= cmd;
        req_bus.address <= addr;
        req_bus.data    <= data;
        do @(posedge i_clk); while (!req_bus.ready);
        items_sent++;
    endtask

    // Stop offering and wait until every result is back, then let the block settle
    task automatic wait_idle();
        req_bus.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_bank_count(input logic [COUNT_W-1:0] value);
        cfg_bus.valid          <= 1'b1;
        cfg_bus.prg_bank_count <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
    endtask

    // Mostly well-formed mapper traffic, with some noise
    task automatic random_traffic();
        int                pick;
        int                n;
        logic [ADDR_W-1:0] a;
        pick = $urandom_range(0, 99);
        if (pick < 16) begin
            // select a bank register, then load it
            send_access(CMD_CPU_WRITE, reg_addr(WIN_BANK, REG_EVEN, 1'b1), 8'($urandom));
            send_access(CMD_CPU_WRITE, reg_addr(WIN_BANK, REG_ODD, 1'b1), 8'($urandom));
        end else if (pick < 26) begin
            // arm the counter with a mostly short latch
            send_access(CMD_CPU_WRITE, reg_addr(WIN_IRQ_LATCH, REG_EVEN, 1'b1),
                        ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6)));
            send_access(CMD_CPU_WRITE, reg_addr(WIN_IRQ_LATCH, REG_ODD, 1'b1), 8'($urandom));
            send_access(CMD_CPU_WRITE,
                        reg_addr(WIN_IRQ_CTRL, ($urandom_range(0, 3) != 0), 1'b1),
                        8'($urandom));
        end else if (pick < 46) begin
            // scanline-like bursts toggling A12
            n = $urandom_range(1, 6);
            repeat (n) begin
                a = 16'($urandom);
                send_access(CMD_PPU_ACCESS, a & ~16'h1000, 8'($urandom));
                send_access(CMD_PPU_ACCESS, a | 16'h1000, 8'($urandom));
            end
        end else if (pick < 60) begin
            send_access(CMD_CPU_READ, 16'($urandom), 8'($urandom));
        end else if (pick < 70) begin
            send_access(CMD_PPU_ACCESS, 16'($urandom), 8'($urandom));
        end else if (pick < 84) begin
            send_access(CMD_CPU_WRITE, {1'b1, 15'($urandom)}, 8'($urandom));
        end else if (pick < 90) begin
            // acknowledge the interrupt
            send_access(CMD_CPU_WRITE, reg_addr(WIN_IRQ_CTRL, REG_EVEN, 1'b1), 8'($urandom));
        end else if (pick < 95) begin
            send_access(CMD_CPU_WRITE, {1'b0, 15'($urandom)}, 8'($urandom));
        end else begin
            send_access(t_cmd'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
        end
    endtask

    initial begin : stimulus
        int                 phase;
        int                 phase_end;
        logic [COUNT_W-1:0] count_val;

        // Known values on every input from time zero
        i_rst_n                = 1'b0;
        req_bus.valid          = 1'b0;
        req_bus.command        = CMD_CPU_WRITE;
        req_bus.address        = '0;
        req_bus.data           = '0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.prg_bank_count = COUNT_RESET;
        gaps_on                = 1'b1;
        hold_asked             = 0;
        items_sent             = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset bank count
        send_access(CMD_CPU_READ, 16'h8000, 8'h00);
        send_access(CMD_CPU_READ, 16'hFFFF, 8'hFF);
        // A15 plays no part in slot selection
        send_access(CMD_CPU_READ, 16'h6000, 8'h00);
        // write below the register space
        send_access(CMD_CPU_WRITE, 16'h7FFF, 8'hFF);
        send_access(CMD_UNUSED, 16'hFFFF, 8'hFF);
        // R6 in PRG mode 1, bank number wraps modulo the count
        send_access(CMD_CPU_WRITE, reg_addr(WIN_BANK, REG_EVEN, 1'b0), 8'h46);
        send_access(CMD_CPU_WRITE, reg_addr(WIN_BANK, REG_ODD, 1'b0), 8'hFF);
        send_access(CMD_CPU_READ, 16'hC000, 8'h00);
        send_access(CMD_CPU_READ, 16'h8ABC, 8'h00);
        // R0 in CHR mode 1, back to PRG mode 0
        send_access(CMD_CPU_WRITE, reg_addr(WIN_BANK, REG_EVEN, 1'b0), 8'h80);
        send_access(CMD_CPU_WRITE, reg_addr(WIN_BANK, REG_ODD, 1'b0), 8'hFF);
        send_access(CMD_PPU_ACCESS, 16'h1000, 8'h00);
        send_access(CMD_CPU_WRITE, reg_addr(WIN_MIRROR, REG_EVEN, 1'b0), 8'h01);
        // RAM protect write has no effect
        send_access(CMD_CPU_WRITE, reg_addr(WIN_MIRROR, REG_ODD, 1'b0), 8'hFF);
        // zero latch with reload fires on the next A12 rise
        send_access(CMD_CPU_WRITE, reg_addr(WIN_IRQ_LATCH, REG_EVEN, 1'b0), 8'h00);
        send_access(CMD_CPU_WRITE, reg_addr(WIN_IRQ_LATCH, REG_ODD, 1'b0), 8'h00);
        send_access(CMD_CPU_WRITE, reg_addr(WIN_IRQ_CTRL, REG_ODD, 1'b0), 8'h00);
        send_access(CMD_PPU_ACCESS, 16'h0000, 8'h00);
        send_access(CMD_PPU_ACCESS, 16'h1FFF, 8'hFF);
        send_access(CMD_PPU_ACCESS, 16'h1400, 8'h00);
        send_access(CMD_CPU_WRITE, reg_addr(WIN_IRQ_CTRL, REG_EVEN, 1'b0), 8'h00);
        // R7 at the largest bank number
        send_access(CMD_CPU_WRITE, reg_addr(WIN_BANK, REG_EVEN, 1'b0), 8'h07);
        send_access(CMD_CPU_WRITE, reg_addr(WIN_BANK, REG_ODD, 1'b0), 8'h3F);
        send_access(CMD_CPU_READ, 16'hA000, 8'h00);
        // only the low 13 bits of a PPU address pick slot and offset
        send_access(CMD_PPU_ACCESS, 16'hFFFF, 8'hFF);

        // Random phases, each under its own bank count
        for (phase = 0; phase < 8; phase++) begin
            wait_idle();
            case (phase)
                0:       count_val = COUNT_MAX;
                1:       count_val = COUNT_MIN;
                2:       count_val = 7'd0;
                3:       count_val = 7'd127;
                4:       count_val = 7'd1;
                5:       count_val = 7'd65;
                6:       count_val = 7'($urandom_range(3, 63));
                default: count_val = COUNT_RESET;
            endcase
            write_bank_count(count_val);
            gaps_on <= phase[0];
            if (phase == 3 || phase == 6) hold_asked <= hold_asked + 1;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                random_traffic();
                if ($urandom_range(0, 47) == 0) gaps_on <= !gaps_on;
            end
        end

        // Drain and give the verdict
        wait_idle();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
